### sv/lkvc_pkg.sv
package lkvc_pkg;

  localparam int CfgW = 5;
  localparam int KeyW = 32;
  localparam int ValW = 32;

  localparam logic [CfgW-1:0] CapReset = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic compare;    // latch the key match of each cell
    logic shift_all;  // put on a new key: whole chain moves back one place
    logic move;       // hit: cells up to the hit move back one place
  } cell_ctrl_t;

endpackage

### sv/lkvc_ifs.sv
interface lkvc_req_if;
  import lkvc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic signed [KeyW-1:0] key;
  logic signed [ValW-1:0] value;
  modport source (output valid, op, key, value, input ready);
  modport sink (input valid, op, key, value, output ready);
endinterface

interface lkvc_rsp_if;
  import lkvc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic signed [ValW-1:0] read_value;
  logic                   evicted;
  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink (input valid, hit, read_value, evicted, output ready);
endinterface

interface lkvc_cfg_if;
  import lkvc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### sv/lkvc_cell.sv
module lkvc_cell
  import lkvc_pkg::*;
#(
  parameter int IDX  = 0,
  parameter int CAPW = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic signed [KeyW-1:0] req_key,
  input  logic [CAPW-1:0]        cap_eff,
  input  logic signed [KeyW-1:0] left_key,
  input  logic signed [ValW-1:0] left_value,
  input  logic                   left_valid,
  input  logic                   hit_ge_right,
  output logic signed [KeyW-1:0] key,
  output logic signed [ValW-1:0] value,
  output logic                   valid,
  output logic                   match,
  output logic                   hit_ge,
  output logic                   drop
);

  localparam logic [CAPW-1:0] Pos     = CAPW'(IDX);
  localparam logic [CAPW-1:0] PosNext = CAPW'(IDX + 1);

  logic shift_en;
  logic keep;

  // a hit here or further back pulls this cell into the move
  assign hit_ge   = match | hit_ge_right;
  assign shift_en = ctrl.shift_all | (ctrl.move & hit_ge);
  // trim everything at or beyond the capacity on insertion
  assign keep     = !ctrl.shift_all || (Pos < cap_eff);
  // entry would land at or beyond the capacity after an insertion
  assign drop     = valid && (PosNext >= cap_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.compare) begin
        match <= valid && (key == req_key);
      end
      if (shift_en) begin
        valid <= left_valid && keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      key   <= left_key;
      value <= left_value;
    end
  end

endmodule

### sv/lru_key_value_cache.sv
// Channel | Dir | Payload                           | Transfer when
// --------+-----+-----------------------------------+----------------------
// req     | in  | op, key, value                    | req.valid & req.ready
// rsp     | out | hit, read_value, evicted          | rsp.valid & rsp.ready
// cfg     | in  | data (capacity)                   | cfg.valid & cfg.ready
//
// Each request passes through ST_COMPARE, which latches the key match in every
// cell, and ST_UPDATE, which moves the chain and loads the response register.
// A new request is taken on the edge that finishes the previous one, and not
// before it; while rsp is taken in time, requests follow with no idle gap.
// Reset is synchronous on rst and empties the chain; capacity returns to 16.
// A full response register holds the update step until rsp takes it.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input logic         clk,
  input logic         rst,
  lkvc_req_if.sink    req,
  lkvc_rsp_if.source  rsp,
  lkvc_cfg_if.sink    cfg
);

  // Wide enough for the capacity register and for every cell position + 1
  localparam int CapW = ($clog2(ENTRIES + 1) > CfgW) ? $clog2(ENTRIES + 1) : CfgW;
  localparam logic [CapW-1:0] EntriesW = CapW'(ENTRIES);

  // The chain is ordered by recency: cell 0 holds the most recent entry,
  // and the valid cells always form an unbroken run from cell 0.

  state_t state, state_next;

  logic [CfgW-1:0]        capacity;
  logic [CapW-1:0]        cap_ext;
  logic [CapW-1:0]        cap_eff;

  logic                   op_q;
  logic signed [KeyW-1:0] key_q;
  logic signed [ValW-1:0] value_q;

  logic                   rsp_valid;
  logic                   rsp_hit;
  logic signed [ValW-1:0] rsp_value;
  logic                   rsp_evicted;

  logic                   req_ready;
  logic                   update;
  logic                   out_free;
  cell_ctrl_t             ctrl;

  logic signed [KeyW-1:0] key_chain   [ENTRIES+1];
  logic signed [ValW-1:0] value_chain [ENTRIES+1];
  logic                   valid_chain [ENTRIES+1];
  logic                   hge_chain   [ENTRIES+1];
  logic [ENTRIES-1:0]     match_vec;
  logic [ENTRIES-1:0]     drop_vec;

  logic                   any_hit;
  logic signed [ValW-1:0] hit_value;
  logic                   put_new;
  logic                   evict;
  logic signed [ValW-1:0] result_value;

  // Configuration: always ready, capacity saturates at the chain length
  assign cfg.ready = 1'b1;
  assign cap_ext   = CapW'(capacity);
  assign cap_eff   = (cap_ext > EntriesW) ? EntriesW : cap_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapReset;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  // Sequencer
  assign out_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    update     = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold here while the previous response waits
        if (out_free) begin
          update    = 1'b1;
          req_ready = 1'b1;
          state_next = req.valid ? ST_COMPARE : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req.ready = req_ready;

  // Latch the request on its transfer
  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      op_q    <= req.op;
      key_q   <= req.key;
      value_q <= req.value;
    end
  end

  // Match results: keys are unique among valid cells, so at most one hits
  assign any_hit = |match_vec;
  assign put_new = (op_q == OP_PUT) && !any_hit;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (match_vec[i] ? value_chain[i+1] : '0);
    end
  end

  assign ctrl.compare   = (state == ST_COMPARE);
  assign ctrl.shift_all = update && put_new;
  assign ctrl.move      = update && any_hit;

  // Front of the chain: the entry that becomes most recent
  assign key_chain[0]     = key_q;
  assign value_chain[0]   = (op_q == OP_PUT) ? value_q : hit_value;
  assign valid_chain[0]   = 1'b1;
  assign hge_chain[ENTRIES] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      lkvc_cell #(
        .IDX  (g),
        .CAPW (CapW)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .req_key      (key_q),
        .cap_eff      (cap_eff),
        .left_key     (key_chain[g]),
        .left_value   (value_chain[g]),
        .left_valid   (valid_chain[g]),
        .hit_ge_right (hge_chain[g+1]),
        .key          (key_chain[g+1]),
        .value        (value_chain[g+1]),
        .valid        (valid_chain[g+1]),
        .match        (match_vec[g]),
        .hit_ge       (hge_chain[g]),
        .drop         (drop_vec[g])
      );
    end
  endgenerate

  // An insertion drops entries when the grown run passes the capacity;
  // with no capacity the new entry itself is dropped
  assign evict = put_new && ((cap_eff == '0) || (|drop_vec));

  always_comb begin
    if (op_q == OP_PUT) begin
      result_value = '0;
    end else if (any_hit) begin
      result_value = hit_value;
    end else begin
      result_value = '1;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (update) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      rsp_hit     <= any_hit;
      rsp_value   <= result_value;
      rsp_evicted <= evict;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;
  assign rsp.evicted    = rsp_evicted;

endmodule
